// ===== design/fsrq_pkg.sv =====
// ============================================================================
// fsrq_pkg: shared types and constants for the fair-share run queue
// Operation codes, table sizes and the controller/datapath link structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fsrq_pkg;

    // table sizing
    localparam int MAX_THREADS = 64;
    localparam int ID_BITS     = 16;
    localparam int VR_W        = 64;
    localparam int IDX_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam logic [VR_W-1:0] WAKE_BONUS_RST = VR_W'(10000);

    // operation codes
    localparam logic [2:0] OP_ENQ    = 3'd0;
    localparam logic [2:0] OP_DEQ    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_BLOCK  = 3'd4;
    localparam logic [2:0] OP_WAKE   = 3'd5;
    localparam logic [2:0] OP_UPDATE = 3'd6;
    localparam logic [2:0] OP_NOP    = 3'd7;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // latch request, clear search results
        logic rd_run;    // read run table at index for the scan
        logic rd_wait;   // read wait list at index
        logic rd_next;   // wait list read at index + 1 (shift)
        logic idx_inc;   // advance index
        logic idx_ld_hit;// index <= matched wait slot
        logic wr_shift;  // write shifted wait entry at index
        logic apply;     // commit the operation, register the result
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic idx_last;   // index at last run table slot
        logic wlen_zero;  // wait list empty
        logic wscan_last; // index at last wait list entry
        logic hit;        // id match found
        logic shift_more; // index + 1 below wait length
    } t_sts;

endpackage

`default_nettype wire

// ===== design/fsrq_ctrl.sv =====
// ============================================================================
// fsrq_ctrl: sequencer for the fair-share run queue
// Steps each request through table scans, wait-list shifting and commit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fsrq_ctrl import fsrq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [2:0] i_operation,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SDRAIN, S_WSCAN, S_WDRAIN, S_WCHK, S_WRD, S_WWR, S_APPLY
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_operation == OP_NOP) begin
                        n_state = S_APPLY;
                    end else if (i_operation == OP_WAKE) begin
                        n_state = i_sts.wlen_zero ? S_APPLY : S_WSCAN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_run  = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.idx_last) n_state = S_SDRAIN;
            end
            S_SDRAIN: n_state = S_APPLY;
            S_WSCAN: begin
                o_cmd.rd_wait = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_sts.wscan_last) n_state = S_WDRAIN;
            end
            S_WDRAIN: n_state = S_WCHK;
            S_WCHK: begin
                if (i_sts.hit) begin
                    o_cmd.idx_ld_hit = 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_WRD: begin
                if (i_sts.shift_more) begin
                    o_cmd.rd_wait = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state = S_WWR;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_WWR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state = S_WRD;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_busy  <= 1'b0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_busy  <= (n_state != S_IDLE);
            o_done  <= (r_state == S_APPLY);
        end
    end

endmodule

`default_nettype wire

// ===== design/fsrq_dp.sv =====
// ============================================================================
// fsrq_dp: storage and arithmetic for the fair-share run queue
// Run table and wait list memories, scan evaluation and commit logic.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fsrq_dp import fsrq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [VR_W-1:0]    i_cfg_data,
    input  wire logic [2:0]         i_operation,
    input  wire logic [ID_BITS-1:0] i_thread_id,
    input  wire logic [VR_W-1:0]    i_vruntime,
    input  wire logic               i_current_valid,
    output logic                    o_found,
    output logic [ID_BITS-1:0]      o_out_id,
    output logic [VR_W-1:0]         o_out_vruntime,
    output logic [VR_W-1:0]         o_min_vr_now,
    output logic [CNT_W-1:0]        o_queued_count,
    output logic                    o_wait_head_valid,
    output logic [ID_BITS-1:0]      o_wait_head_id,
    output logic                    o_table_full
);

    // latched request
    logic [2:0]         r_op;
    logic [ID_BITS-1:0] r_id;
    logic [VR_W-1:0]    r_vr;
    logic               r_cur;

    // architectural state
    logic [VR_W-1:0]        r_bonus;
    logic [VR_W-1:0]        r_min;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_wlen;
    logic [ID_BITS-1:0]     r_whead;
    logic [MAX_THREADS-1:0] r_valid;

    // memories and registered read data
    logic [ID_BITS-1:0] mem_id [MAX_THREADS];
    logic [VR_W-1:0]    mem_vr [MAX_THREADS];
    logic [ID_BITS-1:0] mem_w  [MAX_THREADS];
    logic [ID_BITS-1:0] r_rd_id;
    logic [VR_W-1:0]    r_rd_vr;
    logic [ID_BITS-1:0] r_wrd;

    // scan pipeline
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_pidx;
    logic             r_pv;
    logic             r_pwait;

    // search results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [VR_W-1:0]  r_hit_vr;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_best_ok;
    logic [IDX_W-1:0] r_best_idx;
    logic [ID_BITS-1:0] r_best_id;
    logic [VR_W-1:0]  r_best_vr;

    logic             run_we;
    logic [IDX_W-1:0] run_wa;
    logic             wait_we;
    logic [IDX_W-1:0] wait_wa;
    logic [ID_BITS-1:0] wait_wd;
    logic [IDX_W-1:0] wait_ra;
    logic             wlen_full;
    logic [VR_W-1:0]  wake_vr;
    logic [VR_W-1:0]  cand_a;
    logic [VR_W-1:0]  cand;
    logic             best_better;

    // status to controller
    assign wlen_full        = (r_wlen == CNT_W'(MAX_THREADS));
    assign o_sts.idx_last   = (r_idx == IDX_W'(MAX_THREADS - 1));
    assign o_sts.wlen_zero  = (r_wlen == '0);
    assign o_sts.wscan_last = ({1'b0, r_idx} == CNT_W'(r_wlen - 1'b1));
    assign o_sts.hit        = r_hit;
    assign o_sts.shift_more = (CNT_W'({1'b0, r_idx} + 1'b1) < r_wlen);

    // wake lift and min update arithmetic
    assign wake_vr = (r_vr < r_min) ? ((r_min > r_bonus) ? (r_min - r_bonus) : '0) : r_vr;
    assign cand_a  = r_cur ? r_vr : r_min;
    assign cand    = (r_best_ok && (!r_cur || (r_best_vr < cand_a))) ? r_best_vr : cand_a;

    // minimum ordering: vruntime, then id
    assign best_better = !r_best_ok || (r_rd_vr < r_best_vr) ||
                         ((r_rd_vr == r_best_vr) && (r_rd_id < r_best_id));

    // memory write controls
    assign run_we  = i_cmd.apply && (r_op == OP_ENQ) && (r_hit || r_free_ok);
    assign run_wa  = r_hit ? r_hit_idx : r_free_idx;
    assign wait_we = i_cmd.wr_shift || (i_cmd.apply && (r_op == OP_BLOCK) && !wlen_full);
    assign wait_wa = i_cmd.wr_shift ? r_idx : r_wlen[IDX_W-1:0];
    assign wait_wd = i_cmd.wr_shift ? r_wrd : r_id;
    assign wait_ra = i_cmd.rd_next ? IDX_W'(r_idx + 1'b1) : r_idx;

    // run table memory
    always_ff @(posedge i_clk) begin
        if (run_we) begin
            mem_id[run_wa] <= r_id;
            mem_vr[run_wa] <= r_vr;
        end
        r_rd_id <= mem_id[r_idx];
        r_rd_vr <= mem_vr[r_idx];
    end

    // wait list memory
    always_ff @(posedge i_clk) begin
        if (wait_we) mem_w[wait_wa] <= wait_wd;
        r_wrd <= mem_w[wait_ra];
    end

    // control, search and commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bonus   <= WAKE_BONUS_RST;
            r_min     <= '0;
            r_count   <= '0;
            r_wlen    <= '0;
            r_valid   <= '0;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
            o_found   <= 1'b0;
            o_out_id  <= '0;
            o_out_vruntime <= '0;
            o_table_full   <= 1'b0;
        end else begin
            if (i_cfg_we) r_bonus <= i_cfg_data;

            // pipeline tag for registered read data
            r_pv    <= (i_cmd.rd_run || i_cmd.rd_wait) && !i_cmd.rd_next;
            r_pwait <= i_cmd.rd_wait;
            r_pidx  <= r_idx;

            // index counter
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_ld_hit) begin
                r_idx <= r_hit_idx;
            end else if (i_cmd.idx_inc) begin
                r_idx <= IDX_W'(r_idx + 1'b1);
            end

            if (i_cmd.load) begin
                r_op      <= i_operation;
                r_id      <= i_thread_id;
                r_vr      <= i_vruntime;
                r_cur     <= i_current_valid;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
                r_best_ok <= 1'b0;
            end else if (r_pv && r_pwait) begin
                // oldest matching wait entry
                if (!r_hit && (r_wrd == r_id)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_pidx;
                end
            end else if (r_pv) begin
                if (r_valid[r_pidx]) begin
                    if (!r_hit && (r_rd_id == r_id)) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_pidx;
                        r_hit_vr  <= r_rd_vr;
                    end
                    if (best_better) begin
                        r_best_ok  <= 1'b1;
                        r_best_idx <= r_pidx;
                        r_best_id  <= r_rd_id;
                        r_best_vr  <= r_rd_vr;
                    end
                end else if (!r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_pidx;
                end
            end

            // wait head mirror on shift into slot 0
            if (i_cmd.wr_shift && (r_idx == '0)) r_whead <= r_wrd;

            // commit
            if (i_cmd.apply) begin
                o_found        <= 1'b0;
                o_out_id       <= '0;
                o_out_vruntime <= '0;
                o_table_full   <= 1'b0;
                case (r_op)
                    OP_ENQ: begin
                        if (r_hit || r_free_ok) begin
                            o_found        <= 1'b1;
                            o_out_id       <= r_id;
                            o_out_vruntime <= r_vr;
                            if (!r_hit) begin
                                r_valid[r_free_idx] <= 1'b1;
                                r_count <= CNT_W'(r_count + 1'b1);
                            end
                        end else begin
                            o_table_full <= 1'b1;
                        end
                    end
                    OP_DEQ, OP_PEEK: begin
                        if (r_best_ok) begin
                            o_found        <= 1'b1;
                            o_out_id       <= r_best_id;
                            o_out_vruntime <= r_best_vr;
                            if (r_op == OP_DEQ) begin
                                r_valid[r_best_idx] <= 1'b0;
                                r_count <= CNT_W'(r_count - 1'b1);
                            end
                        end
                    end
                    OP_REMOVE: begin
                        o_out_id <= r_id;
                        if (r_hit) begin
                            o_found        <= 1'b1;
                            o_out_vruntime <= r_hit_vr;
                            r_valid[r_hit_idx] <= 1'b0;
                            r_count <= CNT_W'(r_count - 1'b1);
                        end
                    end
                    OP_BLOCK: begin
                        o_out_id <= r_id;
                        if (wlen_full) begin
                            o_table_full <= 1'b1;
                        end else begin
                            r_wlen <= CNT_W'(r_wlen + 1'b1);
                            if (r_wlen == '0) r_whead <= r_id;
                            if (r_hit) begin
                                o_found        <= 1'b1;
                                o_out_vruntime <= r_hit_vr;
                                r_valid[r_hit_idx] <= 1'b0;
                                r_count <= CNT_W'(r_count - 1'b1);
                            end
                        end
                    end
                    OP_WAKE: begin
                        o_out_id       <= r_id;
                        o_out_vruntime <= wake_vr;
                        o_found        <= r_hit;
                        if (r_hit) r_wlen <= CNT_W'(r_wlen - 1'b1);
                    end
                    OP_UPDATE: begin
                        if (cand > r_min) r_min <= cand;
                    end
                    default: ;
                endcase
            end
        end
    end

    // live status after the last commit
    assign o_min_vr_now       = r_min;
    assign o_queued_count     = r_count;
    assign o_wait_head_valid  = (r_wlen != '0);
    assign o_wait_head_id     = (r_wlen != '0) ? r_whead : '0;

endmodule

`default_nettype wire

// ===== design/fair_share_run_queue.sv =====
// ============================================================================
// fair_share_run_queue: virtual-runtime run queue with FIFO wait list
// Top level joining the sequencer and the table datapath.
// ============================================================================
//  channel    | signals                                   | handshake
//  -----------+-------------------------------------------+----------------------
//  request    | i_operation i_thread_id i_vruntime        | i_start & !o_busy
//             | i_current_valid                           |
//  result     | o_found o_out_id o_out_vruntime + status  | o_done, one cycle
//  config     | i_cfg_data (wake_bonus)                   | i_cfg_valid & o_cfg_ready
//
//  A run-table request scans all 64 slots through the single read port,
//  then drains, commits and registers its result. Wake scans the wait list,
//  checks for a hit and, when the id is found, shifts each entry behind the
//  woken one down a place. No-op and wake on an empty wait list go straight
//  to commit. o_done appears the cycle after commit; o_busy is low in it.
//  Synchronous active-low reset; no clearing pass. The receiver cannot stall.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fair_share_run_queue import fsrq_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [2:0]         i_operation,
    input  wire logic [ID_BITS-1:0] i_thread_id,
    input  wire logic [VR_W-1:0]    i_vruntime,
    input  wire logic               i_current_valid,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [VR_W-1:0]    i_cfg_data,
    output logic                    o_done,
    output logic                    o_found,
    output logic [ID_BITS-1:0]      o_out_id,
    output logic [VR_W-1:0]         o_out_vruntime,
    output logic [VR_W-1:0]         o_min_vr_now,
    output logic [CNT_W-1:0]        o_queued_count,
    output logic                    o_wait_head_valid,
    output logic [ID_BITS-1:0]      o_wait_head_id,
    output logic                    o_table_full
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = !o_busy;

    fsrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (o_busy),
        .o_done      (o_done)
    );

    fsrq_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_operation        (i_operation),
        .i_thread_id        (i_thread_id),
        .i_vruntime         (i_vruntime),
        .i_current_valid    (i_current_valid),
        .o_found            (o_found),
        .o_out_id           (o_out_id),
        .o_out_vruntime     (o_out_vruntime),
        .o_min_vr_now       (o_min_vr_now),
        .o_queued_count     (o_queued_count),
        .o_wait_head_valid  (o_wait_head_valid),
        .o_wait_head_id     (o_wait_head_id),
        .o_table_full       (o_table_full)
    );

    // a result only closes a request in flight
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without a request in flight");

    // an accepted request raises busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but block not busy");

    // run set never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_queued_count <= CNT_W'(MAX_THREADS))
        else $error("run count beyond table size");

    // a rejected request reports nothing found
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> !o_found)
        else $error("table full with found set");

endmodule

`default_nettype wire

// ===== bench/fsrq_checker.sv =====
// ----------------------------------------------------------------------------
// fsrq_checker: result checker for the fair-share run queue
// Watches the request, config and result channels, keeps its own copy of the
// run table, wait list and minimum vruntime, and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsrq_checker import fsrq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [2:0]         i_operation,
    input  logic [ID_BITS-1:0] i_thread_id,
    input  logic [VR_W-1:0]    i_vruntime,
    input  logic               i_current_valid,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [VR_W-1:0]    i_cfg_data,
    input  logic               i_done,
    input  logic               i_found,
    input  logic [ID_BITS-1:0] i_out_id,
    input  logic [VR_W-1:0]    i_out_vruntime,
    input  logic [VR_W-1:0]    i_min_vr_now,
    input  logic [CNT_W-1:0]   i_queued_count,
    input  logic               i_wait_head_valid,
    input  logic [ID_BITS-1:0] i_wait_head_id,
    input  logic               i_table_full,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic               found;
        logic [ID_BITS-1:0] id;
        logic [VR_W-1:0]    vr;
        logic [VR_W-1:0]    min_vr;
        logic [CNT_W-1:0]   count;
        logic               whv;
        logic [ID_BITS-1:0] whid;
        logic               full;
    } t_sched_result;

    // scheduler state as predicted
    logic               run_used [MAX_THREADS];
    logic [ID_BITS-1:0] run_tid  [MAX_THREADS];
    logic [VR_W-1:0]    run_vr   [MAX_THREADS];
    logic [ID_BITS-1:0] waiters  [$];
    logic [VR_W-1:0]    min_vr;
    logic [VR_W-1:0]    bonus;
    int                 run_cnt;
    t_sched_result      expected_results [$];

    function automatic int slot_of(logic [ID_BITS-1:0] id);
        for (int k = 0; k < MAX_THREADS; k++)
            if (run_used[k] && run_tid[k] == id) return k;
        return -1;
    endfunction

    function automatic int slot_of_min();
        int b;
        b = -1;
        for (int k = 0; k < MAX_THREADS; k++) begin
            if (!run_used[k]) continue;
            if (b < 0 || run_vr[k] < run_vr[b] ||
                (run_vr[k] == run_vr[b] && run_tid[k] < run_tid[b])) b = k;
        end
        return b;
    endfunction

    // apply one request to the predicted state and queue its result
    task automatic schedule_op(logic [2:0] op, logic [ID_BITS-1:0] id,
                               logic [VR_W-1:0] vr, logic cur);
        t_sched_result r;
        int s;
        int w;
        logic [VR_W-1:0] cand;
        r = '0;
        case (op)
            OP_ENQ: begin
                s = slot_of(id);
                if (s >= 0) begin
                    run_vr[s] = vr;
                    r.found = 1'b1; r.id = id; r.vr = vr;
                end else begin
                    w = 0;
                    while (w < MAX_THREADS && run_used[w]) w++;
                    if (w >= MAX_THREADS) r.full = 1'b1;
                    else begin
                        run_used[w] = 1'b1; run_tid[w] = id; run_vr[w] = vr;
                        run_cnt++;
                        r.found = 1'b1; r.id = id; r.vr = vr;
                    end
                end
            end
            OP_DEQ, OP_PEEK: begin
                s = slot_of_min();
                if (s >= 0) begin
                    r.found = 1'b1; r.id = run_tid[s]; r.vr = run_vr[s];
                    if (op == OP_DEQ) begin
                        run_used[s] = 1'b0; run_cnt--;
                    end
                end
            end
            OP_REMOVE: begin
                r.id = id;
                s = slot_of(id);
                if (s >= 0) begin
                    r.found = 1'b1; r.vr = run_vr[s];
                    run_used[s] = 1'b0; run_cnt--;
                end
            end
            OP_BLOCK: begin
                r.id = id;
                if (waiters.size() >= MAX_THREADS) r.full = 1'b1;
                else begin
                    waiters.push_back(id);
                    s = slot_of(id);
                    if (s >= 0) begin
                        r.found = 1'b1; r.vr = run_vr[s];
                        run_used[s] = 1'b0; run_cnt--;
                    end
                end
            end
            OP_WAKE: begin
                r.id = id;
                for (w = 0; w < waiters.size(); w++)
                    if (waiters[w] == id) break;
                if (w < waiters.size()) begin
                    r.found = 1'b1;
                    waiters.delete(w);
                end
                if (vr < min_vr) vr = (min_vr > bonus) ? min_vr - bonus : '0;
                r.vr = vr;
            end
            OP_UPDATE: begin
                cand = cur ? vr : min_vr;
                s = slot_of_min();
                if (s >= 0 && (!cur || run_vr[s] < cand)) cand = run_vr[s];
                if (cand > min_vr) min_vr = cand;
            end
            default: ;
        endcase
        r.min_vr = min_vr;
        r.count  = CNT_W'(run_cnt);
        r.whv    = waiters.size() > 0;
        r.whid   = waiters.size() > 0 ? waiters[0] : '0;
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [VR_W-1:0] got,
                                   logic [VR_W-1:0] want);
        $display("%0t fsrq_checker: %s got %0h want %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_sched_result e;
        if (!i_rst_n) begin
            foreach (run_used[k]) run_used[k] = 1'b0;
            waiters.delete();
            min_vr  = '0;
            bonus   = WAKE_BONUS_RST;
            run_cnt = 0;
        end else begin
            // result first: it belongs to a request accepted earlier
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected", '0, '0);
                end else begin
                    e = expected_results.pop_front();
                    if (i_found != e.found)
                        report_mismatch("found", VR_W'(i_found), VR_W'(e.found));
                    if (i_out_id != e.id)
                        report_mismatch("out_id", VR_W'(i_out_id), VR_W'(e.id));
                    if (i_out_vruntime != e.vr)
                        report_mismatch("out_vruntime", i_out_vruntime, e.vr);
                    if (i_min_vr_now != e.min_vr)
                        report_mismatch("min_vr_now", i_min_vr_now, e.min_vr);
                    if (i_queued_count != e.count)
                        report_mismatch("queued_count", VR_W'(i_queued_count),
                                        VR_W'(e.count));
                    if (i_wait_head_valid != e.whv)
                        report_mismatch("wait_head_valid", VR_W'(i_wait_head_valid),
                                        VR_W'(e.whv));
                    if (i_wait_head_id != e.whid)
                        report_mismatch("wait_head_id", VR_W'(i_wait_head_id),
                                        VR_W'(e.whid));
                    if (i_table_full != e.full)
                        report_mismatch("table_full", VR_W'(i_table_full), VR_W'(e.full));
                end
            end
            if (i_cfg_valid && i_cfg_ready) bonus = i_cfg_data;
            if (i_start && !i_busy)
                schedule_op(i_operation, i_thread_id, i_vruntime, i_current_valid);
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the fair-share run queue
// Directed corner cases, then phases of random requests with sender gaps and
// wake_bonus rewrites between phases; checking is done in fsrq_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import fsrq_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_start = 0;
    logic [2:0]         i_operation = OP_NOP;
    logic [ID_BITS-1:0] i_thread_id = '0;
    logic [VR_W-1:0]    i_vruntime = '0;
    logic               i_current_valid = 0;
    logic               i_cfg_valid = 0;
    logic [VR_W-1:0]    i_cfg_data = '0;
    logic               o_busy, o_cfg_ready, o_done, o_found, o_wait_head_valid;
    logic               o_table_full;
    logic [ID_BITS-1:0] o_out_id, o_wait_head_id;
    logic [VR_W-1:0]    o_out_vruntime, o_min_vr_now;
    logic [CNT_W-1:0]   o_queued_count;
    int                 fail_count, pending;
    int                 gap_pct;
    logic [ID_BITS-1:0] id_pool [8];

    always #5 i_clk = ~i_clk;

    fair_share_run_queue uut (.*);

    fsrq_checker chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_operation, .i_thread_id,
        .i_vruntime, .i_current_valid, .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_data, .i_done(o_done), .i_found(o_found), .i_out_id(o_out_id),
        .i_out_vruntime(o_out_vruntime), .i_min_vr_now(o_min_vr_now),
        .i_queued_count(o_queued_count), .i_wait_head_valid(o_wait_head_valid),
        .i_wait_head_id(o_wait_head_id), .i_table_full(o_table_full),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [VR_W-1:0] rand_vr();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {$urandom, $urandom};
            default: return VR_W'($urandom_range(0, 200000));
        endcase
    endfunction

    // issue one request and hold it until it is taken
    task automatic send_request(logic [2:0] op, logic [ID_BITS-1:0] id,
                                logic [VR_W-1:0] vr, logic cur);
        while ($urandom_range(0, 99) < gap_pct) @(negedge i_clk);
        i_start = 1; i_operation = op; i_thread_id = id;
        i_vruntime = vr; i_current_valid = cur;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        i_start = 0;
        i_operation = 3'($urandom); i_thread_id = 16'($urandom);
        i_vruntime = {$urandom, $urandom};
    endtask

    // wait for all results, then a margin before touching the register
    task automatic drain_and_configure(logic [VR_W-1:0] val);
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_valid = 1; i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic random_phase(int n, int pct);
        logic [2:0] op;
        gap_pct = pct;
        for (int k = 0; k < n; k++) begin
            op = 3'($urandom_range(0, 7));
            // bias towards enqueue so the table fills and full cases are hit
            if ($urandom_range(0, 3) == 0) op = OP_ENQ;
            send_request(op, $urandom_range(0, 9) == 0 ? 16'($urandom) :
                         id_pool[$urandom_range(0, 7)], rand_vr(), 1'($urandom));
            if (k % 150 == 75)
                for (int f = 0; f < 70; f++)
                    send_request($urandom_range(0, 1) ? OP_ENQ : OP_BLOCK,
                                 16'($urandom), rand_vr(), 1'b0);
        end
    endtask

    initial begin
        gap_pct = 0;
        foreach (id_pool[k]) id_pool[k] = 16'($urandom);
        id_pool[0] = '0; id_pool[1] = '1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1;

        // directed: empty set, extremes, wake clamp, update min
        send_request(OP_DEQ, '0, '0, 1'b0);
        send_request(OP_PEEK, '0, '0, 1'b0);
        send_request(OP_REMOVE, 16'hffff, '0, 1'b0);
        send_request(OP_ENQ, 16'hffff, '1, 1'b0);
        send_request(OP_ENQ, 16'h0000, '1, 1'b0);
        send_request(OP_ENQ, 16'h0000, 64'd500, 1'b0);
        send_request(OP_ENQ, 16'h1234, 64'd500, 1'b0);
        send_request(OP_PEEK, '0, '0, 1'b0);
        send_request(OP_UPDATE, '0, 64'd20000, 1'b1);
        send_request(OP_UPDATE, '0, 64'd100, 1'b1);
        send_request(OP_UPDATE, '0, '0, 1'b0);
        send_request(OP_BLOCK, 16'h1234, '0, 1'b0);
        send_request(OP_BLOCK, 16'h4321, '0, 1'b0);
        send_request(OP_BLOCK, 16'h1234, '0, 1'b0);
        send_request(OP_WAKE, 16'h1234, '0, 1'b0);
        send_request(OP_WAKE, 16'h9999, 64'd3, 1'b0);
        send_request(OP_WAKE, 16'h4321, '1, 1'b0);
        send_request(OP_REMOVE, 16'hffff, '0, 1'b0);
        send_request(OP_DEQ, '0, '0, 1'b0);
        send_request(OP_NOP, '0, '0, 1'b1);
        drain_and_configure('0);
        send_request(OP_WAKE, 16'h1234, '0, 1'b0);
        drain_and_configure('1);
        send_request(OP_WAKE, 16'h0001, '0, 1'b0);

        // random phases with varied sender gaps and register settings
        drain_and_configure(64'd10000);
        random_phase(200, 0);
        drain_and_configure(64'd1);
        random_phase(200, 53);
        drain_and_configure({$urandom, $urandom});
        random_phase(200, 20);
        drain_and_configure('1);
        random_phase(200, 0);
        drain_and_configure('0);
        random_phase(100, 53);

        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        if (fail_count == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
